FILE: hw/rtl/bps_pkg.sv
// Shared constants, register map and byte folding for the byte pattern search block.
`default_nettype none

package bps_pkg;

	localparam int unsigned DEF_MAX_PATTERN = 32;
	localparam int unsigned DEF_OFFSET_BITS = 32;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned OUT_FIELD_W = 32;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_FOLD_CASE = 1'b0,
		REG_HIT_LIMIT = 1'b1
	} reg_idx_t;

	localparam logic MODE_PATTERN = 1'b0;
	localparam logic MODE_TEXT    = 1'b1;

	// fold ASCII upper case to lower case when enabled
	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
		logic [7:0] r;
		r = b;
		if (en && b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'd32;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/byte_pattern_search.sv
// Top level of the byte pattern search block: input stage, parallel window compare, result register.
`default_nettype none

//  channel   dir  tdata                          tuser      tlast
//  s_*       in   [7:0] data_byte                mode       is_last
//  m_*       out  [31:0] match_offset,           is_hit     done_res
//                 [63:32] hits_so_far
//  APB       in   paddr 0: fold_case, 4: hit_limit (read back on prdata)
//
// Each beat passes through the input stage and then the result register;
// one beat is accepted every cycle while the result side keeps up. The whole
// window of MAX_PATTERN bytes is compared against the pattern in parallel in
// the input stage. Reset clears pattern length, load flag, offsets and hit count;
// pattern and window bytes need no reset. A stall on m_tready holds the result
// and the input stage, so at most one further beat is taken while a result waits.
module byte_pattern_search #(
	parameter int unsigned MAX_PATTERN = bps_pkg::DEF_MAX_PATTERN,
	parameter int unsigned OFFSET_BITS = bps_pkg::DEF_OFFSET_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// slave side
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	input  wire logic [7:0]                      s_tdata,   // [7:0] data_byte
	input  wire logic                            s_tuser,   // [0] mode
	input  wire logic                            s_tlast,   // is_last
	// master side
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	output      logic [2*bps_pkg::OUT_FIELD_W-1:0] m_tdata, // [31:0] match_offset, [63:32] hits_so_far
	output      logic                            m_tuser,   // [0] is_hit
	output      logic                            m_tlast,   // done_res
	// configuration
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [bps_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [bps_pkg::APB_DATA_W-1:0]  pwdata,
	output      logic [bps_pkg::APB_DATA_W-1:0]  prdata,
	output      logic                            pready
);
	import bps_pkg::*;

	localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int unsigned OW    = (OFFSET_BITS > OUT_FIELD_W) ? OFFSET_BITS : OUT_FIELD_W;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

	// configuration registers
	logic                    fold_case_q;
	logic [OUT_FIELD_W-1:0]  hit_limit_q;
	logic                    cfg_wr;
	reg_idx_t                cfg_idx;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       mode_s1;
	logic       last_s1;
	logic       go_s1;
	logic       out_free;

	// block state
	logic [7:0]             pat_q [MAX_PATTERN];
	logic [7:0]             win_q [MAX_PATTERN];
	logic [LEN_W-1:0]       len_q;
	logic                   loading_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OUT_FIELD_W-1:0] cnt_q;

	// compare stage
	logic [7:0]             win_nxt [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] lane_ok;
	logic [OFFSET_BITS-1:0] pos_nxt;
	logic                   is_text;
	logic                   win_match;
	logic                   under_limit;
	logic                   hit;
	logic                   emit;
	logic [OUT_FIELD_W-1:0] cnt_nxt;
	logic [OW-1:0]          start_w;

	// result register
	logic                   valid_s2;
	logic                   hit_s2;
	logic                   done_s2;
	logic [OUT_FIELD_W-1:0] offset_s2;
	logic [OUT_FIELD_W-1:0] count_s2;

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (cfg_idx)
			REG_FOLD_CASE: prdata = {{(APB_DATA_W-1){1'b0}}, fold_case_q};
			REG_HIT_LIMIT: prdata = hit_limit_q;
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_case_q <= 1'b0;
			hit_limit_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_FOLD_CASE: fold_case_q <= pwdata[0];
				REG_HIT_LIMIT: hit_limit_q <= pwdata;
				default:       ;
			endcase
		end
	end

	// ---------------------------------------------------------------- handshake
	// The stage advances whenever the result register can take a beat; a
	// beat that yields no result still waits for that slot, which keeps
	// s_tready free of the compare logic.
	assign out_free = !valid_s2 || m_tready;
	assign go_s1    = valid_s1 && out_free;
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			mode_s1 <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	// ---------------------------------------------------------------- compare
	// The pattern is kept right-aligned: its newest byte sits in the top lane,
	// the same lane as the newest text byte, so lane p always compares
	// pattern lane p with window lane p. Lanes below MAX_PATTERN - len are masked.
	assign is_text = (mode_s1 == MODE_TEXT);
	assign pos_nxt = (pos_q != '1) ? pos_q + 1'b1 : pos_q;

	always_comb begin
		for (int p = 0; p < MAX_PATTERN - 1; p++) begin
			win_nxt[p] = win_q[p + 1];
		end
		win_nxt[MAX_PATTERN-1] = byte_s1;
	end

	always_comb begin
		for (int p = 0; p < MAX_PATTERN; p++) begin
			lane_ok[p] = (LEN_W'(MAX_PATTERN - 1 - p) >= len_q) ||
				(fold_byte(win_nxt[p], fold_case_q) == fold_byte(pat_q[p], fold_case_q));
		end
	end

	assign win_match   = (len_q != '0) && (OW'(pos_nxt) >= OW'(len_q)) && (&lane_ok);
	assign under_limit = (hit_limit_q == '0) || (cnt_q < hit_limit_q);
	assign hit         = is_text && win_match && under_limit;
	assign emit        = is_text && (hit || last_s1);
	assign cnt_nxt     = (hit && cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
	assign start_w     = OW'(pos_nxt) - OW'(len_q);

	// ---------------------------------------------------------------- state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			loading_q <= 1'b0;
			pos_q     <= '0;
			cnt_q     <= '0;
		end else if (go_s1) begin
			if (is_text) begin
				// restart offsets and hit count after the last text byte
				pos_q <= last_s1 ? '0 : pos_nxt;
				cnt_q <= last_s1 ? '0 : cnt_nxt;
			end else begin
				loading_q <= !last_s1;
				if (!loading_q) begin
					len_q <= LEN_W'(1);
				end else if (len_q != LEN_MAX) begin
					len_q <= len_q + 1'b1;
				end
			end
		end
	end

	// pattern and window lanes carry data only, no reset
	always_ff @(posedge clk) begin
		if (go_s1 && is_text) begin
			win_q <= win_nxt;
		end
		// drop pattern bytes beyond the store, unless a new load starts
		if (go_s1 && !is_text && (!loading_q || len_q != LEN_MAX)) begin
			for (int p = 0; p < MAX_PATTERN - 1; p++) begin
				pat_q[p] <= pat_q[p + 1];
			end
			pat_q[MAX_PATTERN-1] <= byte_s1;
		end
	end

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= go_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			hit_s2    <= hit;
			done_s2   <= last_s1;
			offset_s2 <= hit ? start_w[OUT_FIELD_W-1:0] : '0;
			count_s2  <= cnt_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = hit_s2;
	assign m_tlast  = done_s2;
	assign m_tdata  = {count_s2, offset_s2};

	// ---------------------------------------------------------------- checks
	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_MAX)
		else $error("pattern length beyond store");

	a_pattern_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && !is_text |=> !valid_s2 || $stable(valid_s2) && $past(valid_s2))
		else $error("pattern beat produced a result");

	a_done_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && is_text && last_s1 |=> pos_q == '0 && cnt_q == '0)
		else $error("offsets not restarted after last text beat");

	a_limit_kept: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && hit && hit_limit_q != '0 |-> cnt_nxt <= hit_limit_q)
		else $error("hit reported beyond limit");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the byte pattern search block: stream stimulus, prediction, checks.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_PAT = bps_pkg::DEF_MAX_PATTERN;

	// one slave-side beat, as the block sees it
	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
		logic       is_last;
	} search_item_t;

	// one master-side beat
	typedef struct packed {
		logic        is_hit;
		logic [31:0] match_offset;
		logic [31:0] hits_so_far;
		logic        done_res;
	} search_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
	logic        s_tuser = 1'b0;    // [0] mode
	logic        s_tlast = 1'b0;    // is_last

	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;           // [31:0] match_offset, [63:32] hits_so_far
	logic        m_tuser;           // [0] is_hit
	logic        m_tlast;           // done_res

	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [bps_pkg::APB_ADDR_W-1:0]  paddr = '0;
	logic [bps_pkg::APB_DATA_W-1:0]  pwdata = '0;
	logic [bps_pkg::APB_DATA_W-1:0]  prdata;
	logic                            pready;

	byte_pattern_search u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: our own copy of the pattern, window and counters,
	// plus the register values last written over the configuration port.
	// ------------------------------------------------------------------
	logic        fold_en = 1'b0;
	logic [31:0] hit_cap = '0;

	logic [7:0]  pat_bytes [MAX_PAT];
	int          pat_len = 0;
	logic        pat_loading = 1'b0;
	logic [7:0]  text_win [MAX_PAT];
	logic [31:0] text_pos = '0;
	logic [31:0] hit_cnt = '0;

	search_item_t   byte_stream_q[$];    // beats waiting for the driver
	search_result_t match_reports_q[$];  // predicted reports, oldest first

	int n_errors = 0;
	int n_queued = 0;
	int n_hits_seen = 0;
	int n_texts_seen = 0;
	int n_settings = 0;

	// Fold ASCII upper case to lower case while folding is enabled.
	function automatic logic [7:0] lower_if_folding(input logic [7:0] b);
		if (fold_en && b >= "A" && b <= "Z")
			return b + 8'd32;
		return b;
	endfunction

	// Advance the predictor by one accepted beat; queue the report it causes, if any.
	function automatic void scan_byte(input search_item_t it);
		logic           match;
		logic [31:0]    start;
		int             base;
		search_result_t rep;
		if (it.mode == bps_pkg::MODE_PATTERN) begin
			// the first byte of a new load drops the old pattern; excess bytes fall away
			if (!pat_loading)
				pat_len = 0;
			if (pat_len < MAX_PAT) begin
				pat_bytes[pat_len] = it.data_byte;
				pat_len++;
			end
			pat_loading = !it.is_last;
			return;
		end
		for (int k = 0; k < MAX_PAT - 1; k++)
			text_win[k] = text_win[k + 1];
		text_win[MAX_PAT - 1] = it.data_byte;
		if (text_pos != '1)
			text_pos++;
		// an empty pattern or a text still shorter than the pattern cannot match
		match = (pat_len != 0) && (text_pos >= 32'(pat_len));
		base = MAX_PAT - pat_len;
		for (int k = 0; k < pat_len; k++)
			if (lower_if_folding(text_win[base + k]) != lower_if_folding(pat_bytes[k]))
				match = 1'b0;
		start = '0;
		if (match && (hit_cap == 0 || hit_cnt < hit_cap)) begin
			start = text_pos - 32'(pat_len);
			if (hit_cnt != '1)
				hit_cnt++;
		end else begin
			match = 1'b0;
		end
		if (!match && !it.is_last)
			return;
		rep.is_hit       = match;
		rep.match_offset = start;
		rep.hits_so_far  = hit_cnt;
		rep.done_res     = it.is_last;
		match_reports_q.push_back(rep);
		// the last text byte restarts offsets and hit counting
		if (it.is_last) begin
			text_pos = '0;
			hit_cnt  = '0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: present queued beats, hold each until accepted, insert gaps.
	// ------------------------------------------------------------------
	search_item_t cur_item;
	int           drv_gap = 0;
	int           drv_calm = 0;

	// Pick the idle gap after a beat: mostly short, a few long, with gapless stretches.
	function automatic int pick_drv_gap();
		int r;
		if (drv_calm > 0) begin
			drv_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			drv_calm = $urandom_range(30, 80);
			return 0;
		end
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	always @(posedge clk) begin : drive_stream
		search_item_t nxt;
		if (arst_n) begin
			// predict from the beat that this edge accepts
			if (s_tvalid && s_tready)
				scan_byte(cur_item);
			if (!s_tvalid || s_tready) begin
				if (drv_gap != 0) begin
					drv_gap  <= drv_gap - 1;
					s_tvalid <= 1'b0;
				end else if (byte_stream_q.size() != 0) begin
					nxt = byte_stream_q.pop_front();
					cur_item <= nxt;
					s_tdata  <= nxt.data_byte;
					s_tuser  <= nxt.mode;
					s_tlast  <= nxt.is_last;
					s_tvalid <= 1'b1;
					drv_gap  <= pick_drv_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: stall the result side at random and check every report beat.
	// ------------------------------------------------------------------
	int mon_stall = 0;
	int mon_calm = 0;

	always @(posedge clk) begin : watch_reports
		search_result_t want;
		search_result_t got;
		logic           rdy;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.is_hit       = m_tuser;
				got.match_offset = m_tdata[31:0];
				got.hits_so_far  = m_tdata[63:32];
				got.done_res     = m_tlast;
				if (got.is_hit)
					n_hits_seen++;
				if (got.done_res)
					n_texts_seen++;
				if (match_reports_q.size() == 0) begin
					$error("unexpected report beat: is_hit %0b offset %0d hits %0d done %0b",
						got.is_hit, got.match_offset, got.hits_so_far, got.done_res);
					n_errors++;
				end else begin
					want = match_reports_q.pop_front();
					if (got.is_hit !== want.is_hit) begin
						$error("is_hit: expected %0b, got %0b", want.is_hit, got.is_hit);
						n_errors++;
					end
					if (got.match_offset !== want.match_offset) begin
						$error("match_offset: expected %0d, got %0d",
							want.match_offset, got.match_offset);
						n_errors++;
					end
					if (got.hits_so_far !== want.hits_so_far) begin
						$error("hits_so_far: expected %0d, got %0d",
							want.hits_so_far, got.hits_so_far);
						n_errors++;
					end
					if (got.done_res !== want.done_res) begin
						$error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
						n_errors++;
					end
				end
			end
			// choose the ready level for the next cycle
			if (mon_calm > 0) begin
				mon_calm--;
				rdy = 1'b1;
			end else if (mon_stall > 0) begin
				mon_stall--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				case ($urandom_range(0, 99)) inside
					[0:1]:   mon_calm = $urandom_range(30, 80);
					[2:59]:  ;
					[60:94]: mon_stall = $urandom_range(1, 3);
					default: mon_stall = $urandom_range(10, 30);
				endcase
			end
			m_tready <= rdy;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	logic [7:0] gen_pat [64];   // pattern most recently loaded by the generator
	int         gen_len = 0;

	task automatic add_item(input logic mode, input logic [7:0] b, input logic last);
		search_item_t it;
		it.mode      = mode;
		it.data_byte = b;
		it.is_last   = last;
		byte_stream_q.push_back(it);
		n_queued++;
	endtask

	// Mostly a small alphabet so matches are common, plus the case-fold borders and noise.
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			case ($urandom_range(0, 3))
				0:       return "a";
				1:       return "b";
				2:       return "A";
				default: return "B";
			endcase
		end
		if (r < 70) begin
			case ($urandom_range(0, 7))
				0:       return 8'h40;
				1:       return "A";
				2:       return "Z";
				3:       return 8'h5B;
				4:       return 8'h60;
				5:       return "a";
				6:       return "z";
				default: return 8'h7B;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Flip the case of a letter now and then, so folding matters.
	function automatic logic [7:0] maybe_flip(input logic [7:0] b);
		if ($urandom_range(0, 9) < 3 && ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")))
			return b ^ 8'h20;
		return b;
	endfunction

	// Load a fresh pattern; lengths past the store size check the truncation.
	task automatic add_pattern();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			gen_len = $urandom_range(1, 4);
		else if (r < 95)
			gen_len = $urandom_range(5, 12);
		else
			gen_len = $urandom_range(MAX_PAT - 2, MAX_PAT + 4);
		for (int k = 0; k < gen_len; k++) begin
			gen_pat[k] = pick_byte();
			add_item(bps_pkg::MODE_PATTERN, gen_pat[k], k == gen_len - 1);
			// a text byte in the middle of a load is matched against the partial pattern
			if (k != gen_len - 1 && $urandom_range(0, 19) == 0)
				add_item(bps_pkg::MODE_TEXT, pick_byte(), 1'b0);
		end
	endtask

	// Send one text ending in a last byte.
	task automatic add_text();
		logic [7:0] bytes[$];
		int         len;
		int         pi;
		if (gen_len != 0 && $urandom_range(0, 9) < 3) begin
			// echo the pattern between a short prefix and tail
			repeat ($urandom_range(0, 3)) bytes.push_back(pick_byte());
			for (int k = 0; k < gen_len; k++)
				bytes.push_back(maybe_flip(gen_pat[k]));
			repeat ($urandom_range(0, 3)) bytes.push_back(pick_byte());
		end else begin
			len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(17, 45);
			pi = 0;
			repeat (len) begin
				if (gen_len != 0 && $urandom_range(0, 9) < 4) begin
					bytes.push_back(maybe_flip(gen_pat[pi % gen_len]));
					pi++;
				end else begin
					bytes.push_back(pick_byte());
				end
			end
		end
		foreach (bytes[k]) begin
			add_item(bps_pkg::MODE_TEXT, bytes[k], k == bytes.size() - 1);
			// noise: a stray one-byte pattern load in the middle of a text
			if (k != bytes.size() - 1 && $urandom_range(0, 49) == 0)
				add_item(bps_pkg::MODE_PATTERN, pick_byte(), 1'b1);
		end
	endtask

	task automatic add_random(input int n);
		int stop_at;
		stop_at = n_queued + n;
		while (n_queued < stop_at) begin
			if (gen_len == 0 || $urandom_range(0, 3) == 0)
				add_pattern();
			else
				add_text();
		end
	endtask

	// Wait until every beat is accepted and every report has come, then let the pipe settle.
	task automatic wait_idle();
		@(negedge clk);
		while (byte_stream_q.size() != 0 || s_tvalid || match_reports_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// APB write with a setup and an access phase; the predictor takes the new value once the write edge has passed.
	task automatic write_reg(input bps_pkg::reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		case (idx)
			bps_pkg::REG_FOLD_CASE: fold_en = val[0];
			bps_pkg::REG_HIT_LIMIT: hit_cap = val;
		endcase
		n_settings++;
	endtask

	task automatic set_config(input logic fold, input logic [31:0] cap);
		write_reg(bps_pkg::REG_FOLD_CASE, {31'd0, fold});
		write_reg(bps_pkg::REG_HIT_LIMIT, cap);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : run_test
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		set_config(1'b0, 32'd0);

		// empty pattern: text extremes give only the done report
		add_item(bps_pkg::MODE_TEXT, 8'h00, 1'b0);
		add_item(bps_pkg::MODE_TEXT, 8'hFF, 1'b1);
		// hit on the last byte: a single report with hit and done
		add_item(bps_pkg::MODE_PATTERN, 8'h00, 1'b0);
		add_item(bps_pkg::MODE_PATTERN, 8'hFF, 1'b1);
		add_item(bps_pkg::MODE_TEXT, 8'h00, 1'b0);
		add_item(bps_pkg::MODE_TEXT, 8'hFF, 1'b1);
		// overlapping matches
		add_item(bps_pkg::MODE_PATTERN, "a", 1'b0);
		add_item(bps_pkg::MODE_PATTERN, "a", 1'b1);
		add_item(bps_pkg::MODE_TEXT, "a", 1'b0);
		add_item(bps_pkg::MODE_TEXT, "a", 1'b0);
		add_item(bps_pkg::MODE_TEXT, "a", 1'b1);
		// text shorter than the pattern
		add_item(bps_pkg::MODE_PATTERN, "a", 1'b0);
		add_item(bps_pkg::MODE_PATTERN, "b", 1'b0);
		add_item(bps_pkg::MODE_PATTERN, "c", 1'b1);
		add_item(bps_pkg::MODE_TEXT, "a", 1'b0);
		add_item(bps_pkg::MODE_TEXT, "b", 1'b1);
		// text between pattern bytes sees the partial pattern and keeps the load open
		add_item(bps_pkg::MODE_PATTERN, "x", 1'b0);
		add_item(bps_pkg::MODE_TEXT, "x", 1'b0);
		add_item(bps_pkg::MODE_PATTERN, "y", 1'b1);
		add_item(bps_pkg::MODE_TEXT, "y", 1'b1);
		add_item(bps_pkg::MODE_TEXT, "x", 1'b0);
		add_item(bps_pkg::MODE_TEXT, "y", 1'b1);
		wait_idle();

		// folding on and a limit of one: the second match is not reported as a hit
		set_config(1'b1, 32'd1);
		add_item(bps_pkg::MODE_PATTERN, "A", 1'b0);
		add_item(bps_pkg::MODE_PATTERN, "b", 1'b1);
		add_item(bps_pkg::MODE_TEXT, "a", 1'b0);
		add_item(bps_pkg::MODE_TEXT, "B", 1'b0);
		add_item(bps_pkg::MODE_TEXT, "x", 1'b0);
		add_item(bps_pkg::MODE_TEXT, "a", 1'b0);
		add_item(bps_pkg::MODE_TEXT, "b", 1'b1);
		wait_idle();

		// random phases; each one drains fully before the next setting
		set_config(1'b0, 32'd0);
		add_random(100);
		wait_idle();
		set_config(1'b1, 32'd0);
		add_random(100);
		wait_idle();
		set_config(1'b1, 32'd2);
		add_random(100);
		wait_idle();
		set_config(1'b0, 32'hFFFF_FFFF);
		add_random(100);
		wait_idle();
		set_config(1'($urandom_range(0, 1)), 32'($urandom_range(1, 3)));
		add_random(100);
		wait_idle();
		set_config(1'b1, 32'd0);
		add_random(100);
		wait_idle();

		repeat (10) @(posedge clk);
		$display("Covered %0d input beats, %0d texts and %0d reported hits over %0d register writes",
			n_queued, n_texts_seen, n_hits_seen, n_settings);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#10_000_000;
		$display("Timeout: %0d reports still expected", match_reports_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

FILE: byte_pattern_search.f
hw/rtl/bps_pkg.sv
hw/rtl/byte_pattern_search.sv
verif/tb_top.sv
